### design/sac_pkg.sv
// Shared constants, row layouts and result types for the set-associative cache.
// The cache top level and the lookup module use these by scoped name.
`default_nettype none

package sac_pkg;

  localparam int unsigned WAY_COUNT    = 16;
  localparam int unsigned SET_COUNT    = 8192;
  localparam int unsigned ADDRESS_BITS = 32;

  localparam int unsigned WAY_W       = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int unsigned ASSOC_W     = $clog2(WAY_COUNT + 1);
  localparam int unsigned SET_IDX_MAX = $clog2(SET_COUNT + 1) - 1;
  localparam int unsigned SET_W       = (SET_IDX_MAX > 0) ? SET_IDX_MAX : 1;
  localparam int unsigned TAG_W       = ADDRESS_BITS;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFF >> (32 - ADDRESS_BITS);

  typedef enum logic [1:0] {
    CFG_LINE_SHIFT = 2'd0,
    CFG_SET_SHIFT  = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_reg_t;

  typedef logic [WAY_COUNT-1:0][TAG_W-1:0] tag_row_t;

  typedef struct packed {
    logic [WAY_COUNT-1:0]            valid;
    logic [WAY_COUNT-1:0]            dirty;
    logic [WAY_COUNT-1:0][WAY_W-1:0] rec;
  } state_row_t;

  localparam int unsigned TAG_ROW_W   = $bits(tag_row_t);
  localparam int unsigned STATE_ROW_W = $bits(state_row_t);

  typedef struct packed {
    logic             hit;
    logic             writeback;
    logic [WAY_W-1:0] way;
    logic             tag_we;
    state_row_t       state;
    tag_row_t         tags;
  } lookup_res_t;

  function automatic state_row_t init_state_row();
    state_row_t r;
    r.valid = '0;
    r.dirty = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      r.rec[w] = WAY_W'(w);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/set_assoc_lru_writeback_cache.sv
// Set-associative write-back LRU cache tag model, top level.
// Each input transaction goes through a set read, then an update, before its result is registered.
// No new transaction is accepted until the read-modify-write of the last set row is done.
// A stalled output holds the update until the result register frees.
// After reset, a clearing pass writes all 8192 state rows, one per cycle, with tready low.
// The tag memory is not cleared; tags are only compared under their valid bits.
`default_nettype none

module set_assoc_lru_writeback_cache (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [4:0]    cfg_data,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [31:0]   s_axis_tdata,   // address
  input  logic [0:0]    s_axis_tuser,   // is_write
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // hit, writeback, way_used, access_count, load_count, store_count,
  // hit_count, miss_count, writeback_count, zero pad
  output logic [199:0]  m_axis_tdata
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t state;

  logic [4:0] offset_bit_count;
  logic [3:0] index_bit_count;
  logic [4:0] ways_in_use;

  logic [sac_pkg::SET_W-1:0]   clr_addr;
  logic [sac_pkg::SET_W-1:0]   cur_set;
  logic [sac_pkg::TAG_W-1:0]   cur_tag;
  logic                        cur_wr;

  logic [31:0] access_cnt;
  logic [31:0] load_cnt;
  logic [31:0] store_cnt;
  logic [31:0] hit_cnt;
  logic [31:0] miss_cnt;
  logic [31:0] wb_cnt;
  logic [31:0] access_cnt_next;
  logic [31:0] load_cnt_next;
  logic [31:0] store_cnt_next;
  logic [31:0] hit_cnt_next;
  logic [31:0] miss_cnt_next;
  logic [31:0] wb_cnt_next;

  logic                        out_valid;
  logic [199:0]                out_data;

  logic                        in_accept;
  logic                        lookup_done;
  logic [3:0]                  ib_eff;
  logic [sac_pkg::ASSOC_W-1:0] assoc_eff;
  logic [31:0]                 addr_m;
  logic [31:0]                 set_full;
  logic [5:0]                  shift;
  logic [sac_pkg::SET_W-1:0]   set_next;
  logic [sac_pkg::TAG_W-1:0]   tag_next;

  logic                           st_we;
  logic [sac_pkg::SET_W-1:0]      st_waddr;
  sac_pkg::state_row_t            st_wdata;
  sac_pkg::state_row_t            st_rdata;
  logic [sac_pkg::STATE_ROW_W-1:0] st_rbits;
  sac_pkg::tag_row_t              tag_rdata;
  logic [sac_pkg::TAG_ROW_W-1:0]  tag_rbits;
  sac_pkg::lookup_res_t           res;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == sac_pkg::CNT_MAX) ? v : v + 32'd1;
  endfunction

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign lookup_done   = (state == ST_LOOKUP) && (!out_valid || m_axis_tready);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_comb begin
    if (index_bit_count > 4'(sac_pkg::SET_IDX_MAX)) begin
      ib_eff = 4'(sac_pkg::SET_IDX_MAX);
    end else begin
      ib_eff = index_bit_count;
    end
    if (ways_in_use == 5'd0) begin
      assoc_eff = sac_pkg::ASSOC_W'(1);
    end else if (ways_in_use > 5'(sac_pkg::WAY_COUNT)) begin
      assoc_eff = sac_pkg::ASSOC_W'(sac_pkg::WAY_COUNT);
    end else begin
      assoc_eff = sac_pkg::ASSOC_W'(ways_in_use);
    end
    addr_m   = s_axis_tdata & sac_pkg::ADDR_MASK;
    set_full = (addr_m >> offset_bit_count) & ~(32'hFFFF_FFFF << ib_eff);
    set_next = set_full[sac_pkg::SET_W-1:0];
    shift    = 6'(offset_bit_count) + 6'(ib_eff);
    tag_next = sac_pkg::TAG_W'(addr_m >> shift);
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_addr;
      st_wdata = sac_pkg::init_state_row();
    end else begin
      st_we    = lookup_done;
      st_waddr = cur_set;
      st_wdata = res.state;
    end
  end

  sac_ram #(
    .ADDR_W (sac_pkg::SET_W),
    .DATA_W (sac_pkg::STATE_ROW_W)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (in_accept),
    .raddr (set_next),
    .rdata (st_rbits)
  );

  sac_ram #(
    .ADDR_W (sac_pkg::SET_W),
    .DATA_W (sac_pkg::TAG_ROW_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (lookup_done && res.tag_we),
    .waddr (cur_set),
    .wdata (res.tags),
    .re    (in_accept),
    .raddr (set_next),
    .rdata (tag_rbits)
  );

  assign st_rdata  = st_rbits;
  assign tag_rdata = tag_rbits;

  sac_lookup u_lookup (
    .tag       (cur_tag),
    .is_write  (cur_wr),
    .assoc     (assoc_eff),
    .state_row (st_rdata),
    .tag_row   (tag_rdata),
    .res       (res)
  );

  always_comb begin
    access_cnt_next = sat_inc(access_cnt);
    load_cnt_next   = cur_wr ? load_cnt : sat_inc(load_cnt);
    store_cnt_next  = cur_wr ? sat_inc(store_cnt) : store_cnt;
    hit_cnt_next    = res.hit ? sat_inc(hit_cnt) : hit_cnt;
    miss_cnt_next   = res.hit ? miss_cnt : sat_inc(miss_cnt);
    wb_cnt_next     = res.writeback ? sat_inc(wb_cnt) : wb_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_CLEAR;
      clr_addr         <= '0;
      out_valid        <= 1'b0;
      offset_bit_count <= 5'd6;
      index_bit_count  <= 4'd6;
      ways_in_use      <= 5'd4;
      access_cnt       <= '0;
      load_cnt         <= '0;
      store_cnt        <= '0;
      hit_cnt          <= '0;
      miss_cnt         <= '0;
      wb_cnt           <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sac_pkg::CFG_LINE_SHIFT: offset_bit_count <= cfg_data;
          sac_pkg::CFG_SET_SHIFT:  index_bit_count  <= cfg_data[3:0];
          sac_pkg::CFG_WAYS:       ways_in_use      <= cfg_data;
          default: ;
        endcase
      end

      out_valid <= lookup_done || (out_valid && !m_axis_tready);

      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (lookup_done) begin
            state      <= ST_IDLE;
            access_cnt <= access_cnt_next;
            load_cnt   <= load_cnt_next;
            store_cnt  <= store_cnt_next;
            hit_cnt    <= hit_cnt_next;
            miss_cnt   <= miss_cnt_next;
            wb_cnt     <= wb_cnt_next;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_set <= set_next;
      cur_tag <= tag_next;
      cur_wr  <= s_axis_tuser[0];
    end
    if (lookup_done) begin
      out_data <= {2'b00, wb_cnt_next, miss_cnt_next, hit_cnt_next, store_cnt_next,
                   load_cnt_next, access_cnt_next, 4'(res.way), res.writeback, res.hit};
    end
  end

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_LOOKUP))
    else $error("accepted transaction did not enter lookup");

  a_hit_no_writeback: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP) |-> !(res.hit && res.writeback))
    else $error("writeback flagged on a hit");

  a_done_loads_output: assert property (@(posedge clk) disable iff (rst)
    lookup_done |=> out_valid)
    else $error("finished lookup did not load the result register");

  a_access_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CLEAR) |=> (access_cnt >= $past(access_cnt)))
    else $error("access counter went backwards");

endmodule

`default_nettype wire

### design/sac_ram.sv
// Generic simple dual-port synchronous RAM with a registered read port.
// No dependencies.
`default_nettype none

module sac_ram #(
  parameter int unsigned ADDR_W = 13,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/sac_lookup.sv
// Tag compare, victim choice and LRU update for one set row.
// Depends on sac_pkg for the row layouts and the result type.
`default_nettype none

module sac_lookup (
  input  logic [sac_pkg::TAG_W-1:0]   tag,
  input  logic                        is_write,
  input  logic [sac_pkg::ASSOC_W-1:0] assoc,
  input  sac_pkg::state_row_t         state_row,
  input  sac_pkg::tag_row_t           tag_row,
  output sac_pkg::lookup_res_t        res
);

  logic [sac_pkg::WAY_COUNT-1:0] hit_vec;
  logic [sac_pkg::WAY_COUNT-1:0] inval_vec;
  logic [sac_pkg::WAY_W-1:0]     hit_way;
  logic [sac_pkg::WAY_W-1:0]     inval_way;
  logic [sac_pkg::WAY_W-1:0]     lru_way;
  logic [sac_pkg::WAY_W-1:0]     way;
  logic [sac_pkg::WAY_W-1:0]     pos;
  logic                          found;
  logic                          any_hit;
  logic                          any_inval;

  always_comb begin
    for (int w = 0; w < sac_pkg::WAY_COUNT; w++) begin
      hit_vec[w]   = (w < int'(assoc)) && state_row.valid[w] && (tag_row[w] == tag);
      inval_vec[w] = (w < int'(assoc)) && !state_row.valid[w];
    end
    any_hit   = |hit_vec;
    any_inval = |inval_vec;
    hit_way   = '0;
    inval_way = '0;
    for (int w = sac_pkg::WAY_COUNT - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = sac_pkg::WAY_W'(w);
      end
      if (inval_vec[w]) begin
        inval_way = sac_pkg::WAY_W'(w);
      end
    end
    lru_way = state_row.rec[sac_pkg::WAY_W'(assoc - 1'b1)];

    if (any_hit) begin
      way = hit_way;
    end else if (any_inval) begin
      way = inval_way;
    end else begin
      way = lru_way;
    end

    found = 1'b0;
    pos   = '0;
    for (int i = sac_pkg::WAY_COUNT - 1; i >= 0; i--) begin
      if ((i < int'(assoc)) && (state_row.rec[i] == way)) begin
        found = 1'b1;
        pos   = sac_pkg::WAY_W'(i);
      end
    end

    res.hit       = any_hit;
    res.writeback = !any_hit && !any_inval && state_row.dirty[way];
    res.way       = way;
    res.tag_we    = !any_hit;
    res.state     = state_row;
    res.tags      = tag_row;

    for (int i = 0; i < sac_pkg::WAY_COUNT; i++) begin
      if (found && (i == 0)) begin
        res.state.rec[i] = way;
      end else if (found && (i > 0) && (i <= int'(pos))) begin
        res.state.rec[i] = state_row.rec[i-1];
      end
    end

    if (any_hit) begin
      res.state.dirty[way] = state_row.dirty[way] | is_write;
    end else begin
      res.state.valid[way] = 1'b1;
      res.state.dirty[way] = is_write;
      res.tags[way]        = tag;
    end
  end

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for set_assoc_lru_writeback_cache.
// It drives loads and stores on the input stream and predicts hit, way, writeback and counters.
// It depends only on sac_pkg and the cache top level.

module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic                      hit;
    logic                      writeback;
    logic [sac_pkg::WAY_W-1:0] way;
    logic [31:0]               accesses;
    logic [31:0]               loads;
    logic [31:0]               stores;
    logic [31:0]               hits;
    logic [31:0]               misses;
    logic [31:0]               writebacks;
  } lookup_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = sac_pkg::CFG_LINE_SHIFT;
  logic [4:0]   cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;

  bit [31:0]                line_tag   [sac_pkg::SET_COUNT][sac_pkg::WAY_COUNT];
  bit                       line_valid [sac_pkg::SET_COUNT][sac_pkg::WAY_COUNT];
  bit                       line_dirty [sac_pkg::SET_COUNT][sac_pkg::WAY_COUNT];
  bit [sac_pkg::WAY_W-1:0]  lru_order  [sac_pkg::SET_COUNT][sac_pkg::WAY_COUNT];
  bit [31:0]        n_access, n_load, n_store, n_hit, n_miss, n_writeback;
  bit [4:0]         line_shift_cfg = 5'd6;
  bit [3:0]         set_shift_cfg = 4'd6;
  bit [4:0]         ways_cfg = 5'd4;

  lookup_t     awaited_lookups[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned cycles = 0;

  set_assoc_lru_writeback_cache i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      m_axis_tready <= 1'b0;
      hold_taken <= 1'b1;
      hold_cycles <= 400;
    end else if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic bit [31:0] bump(bit [31:0] count);
    return (count == sac_pkg::CNT_MAX) ? count : count + 32'd1;
  endfunction

  function automatic int unsigned usable_index_bits();
    int unsigned ib;
    ib = set_shift_cfg;
    while (ib > 0 && (1 << ib) > sac_pkg::SET_COUNT) ib--;
    return ib;
  endfunction

  function automatic int unsigned usable_ways();
    if (ways_cfg < 1) return 1;
    if (ways_cfg > sac_pkg::WAY_COUNT) return sac_pkg::WAY_COUNT;
    return ways_cfg;
  endfunction

  function automatic void move_to_front(int unsigned set_i, int unsigned assoc,
                                        int unsigned way);
    int unsigned pos;
    pos = assoc;
    for (int unsigned i = 0; i < assoc; i++) begin
      if (pos == assoc && lru_order[set_i][i] == way) pos = i;
    end
    if (pos == assoc || pos == 0) return;
    for (int unsigned i = pos; i > 0; i--) lru_order[set_i][i] = lru_order[set_i][i-1];
    lru_order[set_i][0] = sac_pkg::WAY_W'(way);
  endfunction

  function automatic lookup_t predict_lookup(bit wr, bit [31:0] addr);
    lookup_t     r;
    bit [63:0]   a;
    bit [31:0]   tag;
    int unsigned ib, assoc, shift, set_i, victim;
    bit          found, dirty_victim;
    a = 64'(addr & sac_pkg::ADDR_MASK);
    ib = usable_index_bits();
    assoc = usable_ways();
    set_i = 32'((a >> line_shift_cfg) & ((64'd1 << ib) - 1));
    shift = line_shift_cfg + ib;
    tag = (shift >= 32) ? 32'd0 : 32'(a >> shift);
    n_access = bump(n_access);
    if (wr) n_store = bump(n_store);
    else n_load = bump(n_load);
    found = 1'b0;
    dirty_victim = 1'b0;
    victim = assoc;
    for (int unsigned w = 0; w < assoc; w++) begin
      if (!found && line_valid[set_i][w] && line_tag[set_i][w] == tag) begin
        found = 1'b1;
        victim = w;
      end
    end
    if (found) begin
      n_hit = bump(n_hit);
      if (wr) line_dirty[set_i][victim] = 1'b1;
    end else begin
      n_miss = bump(n_miss);
      for (int unsigned w = 0; w < assoc; w++) begin
        if (victim == assoc && !line_valid[set_i][w]) victim = w;
      end
      if (victim == assoc) begin
        victim = lru_order[set_i][assoc-1];
        if (line_dirty[set_i][victim]) begin
          dirty_victim = 1'b1;
          n_writeback = bump(n_writeback);
        end
      end
      line_valid[set_i][victim] = 1'b1;
      line_tag[set_i][victim] = tag;
      line_dirty[set_i][victim] = wr;
    end
    move_to_front(set_i, assoc, victim);
    r.hit = found;
    r.writeback = dirty_victim;
    r.way = sac_pkg::WAY_W'(victim);
    r.accesses = n_access;
    r.loads = n_load;
    r.stores = n_store;
    r.hits = n_hit;
    r.misses = n_miss;
    r.writebacks = n_writeback;
    return r;
  endfunction

  // Most addresses reuse a few sets and a few tags so that hits and evictions are common.
  function automatic bit [31:0] make_addr();
    bit [63:0]   a, tag, set_i;
    int unsigned ib, assoc;
    if ($urandom_range(0, 99) < 15) return $urandom;
    ib = usable_index_bits();
    assoc = usable_ways();
    set_i = 64'($urandom_range(0, 3));
    tag = ($urandom_range(0, 9) == 0) ? 64'($urandom) : 64'($urandom_range(0, assoc + 3));
    a = (tag << (line_shift_cfg + ib))
      | ((set_i & ((64'd1 << ib) - 1)) << line_shift_cfg)
      | (64'($urandom) & ((64'd1 << line_shift_cfg) - 1));
    return a[31:0];
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    lookup_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hit = m_axis_tdata[0];
      got.writeback = m_axis_tdata[1];
      got.way = m_axis_tdata[5:2];
      got.accesses = m_axis_tdata[37:6];
      got.loads = m_axis_tdata[69:38];
      got.stores = m_axis_tdata[101:70];
      got.hits = m_axis_tdata[133:102];
      got.misses = m_axis_tdata[165:134];
      got.writebacks = m_axis_tdata[197:166];
      if (awaited_lookups.size() == 0) begin
        $display("%0t: result transaction with no access outstanding", $time);
        error_count++;
      end else begin
        want = awaited_lookups.pop_front();
        check_field("hit", 32'(want.hit), 32'(got.hit));
        check_field("writeback", 32'(want.writeback), 32'(got.writeback));
        check_field("way_used", 32'(want.way), 32'(got.way));
        check_field("access_count", want.accesses, got.accesses);
        check_field("load_count", want.loads, got.loads);
        check_field("store_count", want.stores, got.stores);
        check_field("hit_count", want.hits, got.hits);
        check_field("miss_count", want.misses, got.misses);
        check_field("writeback_count", want.writebacks, got.writebacks);
      end
    end
  end

  // Entered and left just after a rising edge; tvalid stays high for a back-to-back access.
  task automatic send_access(bit wr, bit [31:0] addr);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= addr;
    s_axis_tuser <= wr;
    do @(posedge clk); while (!s_axis_tready);
    awaited_lookups.push_back(predict_lookup(wr, addr));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (awaited_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(sac_pkg::cfg_reg_t which, bit [4:0] value);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (which)
      sac_pkg::CFG_LINE_SHIFT: line_shift_cfg = value;
      sac_pkg::CFG_SET_SHIFT:  set_shift_cfg = value[3:0];
      sac_pkg::CFG_WAYS:       ways_cfg = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(bit [4:0] line_shift, bit [4:0] set_shift, bit [4:0] ways);
    wait_drained();
    cfg_write(sac_pkg::CFG_LINE_SHIFT, line_shift);
    cfg_write(sac_pkg::CFG_SET_SHIFT, set_shift);
    cfg_write(sac_pkg::CFG_WAYS, ways);
  endtask

  task automatic run_random(int count);
    repeat (count) send_access($urandom_range(0, 1), make_addr());
  endtask

  // Reset geometry: 64-byte lines, 64 sets, 4 ways; set 0 tags step by 0x1000.
  task automatic test_reset_defaults();
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'h0000_003F);
    send_access(1'b0, 32'h0000_1000);
    send_access(1'b1, 32'h0000_2000);
    send_access(1'b0, 32'h0000_3000);
    send_access(1'b0, 32'h0000_1004);
    send_access(1'b0, 32'h0000_4000);
    send_access(1'b0, 32'h0000_0000);
    send_access(1'b1, 32'hFFFF_FFFF);
    send_access(1'b0, 32'hFFFF_FFC0);
    send_access(1'b1, 32'h0000_3000);
    send_access(1'b0, 32'h0000_5000);
    send_access(1'b1, 32'h0000_6000);
  endtask

  // Shrinking the ways without a flush lets a victim come from above the new way count.
  task automatic test_config_corners();
    apply_setting(5'd4, 5'd2, 5'd8);
    run_random(35);
    apply_setting(5'd4, 5'd2, 5'd2);
    run_random(35);
    apply_setting(5'd0, 5'd0, 5'd1);
    run_random(35);
    apply_setting(5'd31, 5'd15, 5'd0);
    run_random(35);
    apply_setting(5'd19, 5'd13, 5'd31);
    run_random(35);
    apply_setting(5'd18, 5'd13, 5'd16);
    run_random(35);
    apply_setting(5'd5, 5'd3, 5'd17);
    run_random(35);
  endtask

  task automatic test_random_traffic();
    apply_setting(5'd6, 5'd3, 5'd4);
    send_idle_pct = 63;
    recv_idle_pct = 28;
    run_random(250);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(250);
  endtask

  task automatic test_output_stall();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= 1'b1;
    run_random(40);
  endtask

  initial begin
    for (int s = 0; s < sac_pkg::SET_COUNT; s++) begin
      for (int w = 0; w < sac_pkg::WAY_COUNT; w++) lru_order[s][w] = sac_pkg::WAY_W'(w);
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 63;
    test_reset_defaults();
    test_config_corners();
    test_random_traffic();
    test_output_stall();
    s_axis_tvalid <= 1'b0;
    while (awaited_lookups.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
